// ===== hdl/bfnb_pkg.sv =====
package bfnb_pkg;

  // Defaults for the top-level parameters
  localparam int WORD_BITS_DEF = 64;
  localparam int NUM_WORDS_DEF = 16;

  // Fixed field widths
  localparam int OP_W   = 2;
  localparam int WIDX_W = 4;
  localparam int DATA_W = 64;
  localparam int IDX_W  = 10;
  localparam int SIZE_W = 11;

  // Bitmap size after reset
  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE     = 2'd0,
    OP_FIND_SET  = 2'd1,
    OP_FIND_ZERO = 2'd2
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [WIDX_W-1:0]  word_index;
    logic [DATA_W-1:0]  word_data;
    logic [IDX_W-1:0]   start_bit;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  bit_index;
  } out_item_t;

endpackage

// ===== hdl/bitmap_find_next_bit_core.sv =====
// Bitmap next-bit search. The bitmap lives in a RAM of NUM_WORDS words of WORD_BITS bits.
// A write item stores one word and returns found = 0; a search item returns the lowest set
// (or clear) bit at or above start_bit and below the configured size, else found = 0.
// After reset the block clears every RAM word in turn and holds in_stall high meanwhile.
// A write item passes through the finish state to the output. A search walks the bitmap
// from word 0 upward through the RAM's single read port, one word per cycle, and stops at
// the first hit or the last word below the size, reading at most ceil(size / WORD_BITS)
// words. Items are taken one at a time; a finished result waits in the output register
// while the next item is accepted.
module bitmap_find_next_bit_core #(
  parameter int WORD_BITS = bfnb_pkg::WORD_BITS_DEF,
  parameter int NUM_WORDS = bfnb_pkg::NUM_WORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // item input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  bfnb_pkg::in_item_t            in_data,
  // result output
  output logic                          out_valid,
  input  logic                          out_stall,
  output bfnb_pkg::out_item_t           out_data,
  // bitmap size register
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bfnb_pkg::SIZE_W-1:0]   cfg_data
);

  localparam int AW         = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int CNT_W      = $clog2(WORD_BITS + 1);
  localparam int POS_W      = $clog2(WORD_BITS);
  localparam int BASE_W     = bfnb_pkg::SIZE_W + 1;
  localparam int TOTAL_BITS = NUM_WORDS * WORD_BITS;
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_WORDS - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t                        state_r;
  logic [AW-1:0]                 clr_addr_r;
  logic [AW-1:0]                 next_addr_r;
  logic [BASE_W-1:0]             base_r;
  logic [bfnb_pkg::IDX_W-1:0]    start_r;
  logic                          want_set_r;
  logic                          res_found_r;
  logic [bfnb_pkg::IDX_W-1:0]    res_idx_r;
  logic                          out_valid_r;
  bfnb_pkg::out_item_t           out_data_r;
  logic [bfnb_pkg::SIZE_W-1:0]   cfg_size_r;

  logic [bfnb_pkg::SIZE_W-1:0]   size_eff;
  logic                          in_acc;
  logic                          out_free;
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [WORD_BITS-1:0]          ram_wdata;
  logic [AW-1:0]                 ram_raddr;
  logic [WORD_BITS-1:0]          ram_rdata;
  logic [BASE_W-1:0]             size_ext;
  logic [BASE_W-1:0]             start_ext;
  logic [BASE_W-1:0]             lo_full;
  logic [BASE_W-1:0]             hi_full;
  logic [BASE_W-1:0]             base_next;
  logic [CNT_W-1:0]              lo;
  logic [CNT_W-1:0]              hi;
  logic                          scan_hit;
  logic [POS_W-1:0]              scan_pos;
  logic                          tail_word;

  // Configuration register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_size_r <= bfnb_pkg::SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cfg_size_r <= cfg_data;
    end
  end

  // Size limited to the bits the RAM holds
  assign size_eff = (32'(cfg_size_r) > TOTAL_BITS) ? bfnb_pkg::SIZE_W'(TOTAL_BITS)
                                                   : cfg_size_r;

  // Handshakes
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // RAM write: clearing pass after reset, else write items straight from the input
  always_comb begin
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = in_acc && (in_data.op == bfnb_pkg::OP_WRITE)
                  && (32'(in_data.word_index) < NUM_WORDS);
      ram_waddr = AW'(in_data.word_index);
      ram_wdata = in_data.word_data[WORD_BITS-1:0];
    end
  end

  // Word 0 is read while idle; during a scan the next word is fetched ahead
  assign ram_raddr = (state_r == ST_SCAN) ? next_addr_r : '0;

  bfnb_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Window of the current word: [start - base, size - base), clamped to the word
  assign size_ext  = BASE_W'(size_eff);
  assign start_ext = BASE_W'(start_r);
  assign lo_full   = (start_ext > base_r) ? (start_ext - base_r) : '0;
  assign hi_full   = size_ext - base_r;
  assign lo        = (lo_full > BASE_W'(WORD_BITS)) ? CNT_W'(WORD_BITS) : CNT_W'(lo_full);
  assign hi        = (hi_full > BASE_W'(WORD_BITS)) ? CNT_W'(WORD_BITS) : CNT_W'(hi_full);
  assign base_next = base_r + BASE_W'(WORD_BITS);
  assign tail_word = (base_next >= size_ext);

  bfnb_word_scan #(
    .WORD_BITS (WORD_BITS)
  ) u_scan (
    .word     (ram_rdata),
    .want_set (want_set_r),
    .lo       (lo),
    .hi       (hi),
    .hit      (scan_hit),
    .pos      (scan_pos)
  );

  // Control and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Output register: loaded from the finish state, emptied when taken
      if ((state_r == ST_FINISH) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + AW'(1);
          if (clr_addr_r == LAST_ADDR) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            start_r     <= in_data.start_bit;
            want_set_r  <= (in_data.op == bfnb_pkg::OP_FIND_SET);
            base_r      <= '0;
            next_addr_r <= AW'(1);
            res_found_r <= 1'b0;
            res_idx_r   <= '0;
            if (((in_data.op == bfnb_pkg::OP_FIND_SET) ||
                 (in_data.op == bfnb_pkg::OP_FIND_ZERO)) &&
                (bfnb_pkg::SIZE_W'(in_data.start_bit) < size_eff)) begin
              state_r <= ST_SCAN;
            end else begin
              state_r <= ST_FINISH;
            end
          end
        end
        ST_SCAN: begin
          if (scan_hit) begin
            res_found_r <= 1'b1;
            res_idx_r   <= bfnb_pkg::IDX_W'(base_r + BASE_W'(scan_pos));
            state_r     <= ST_FINISH;
          end else if (tail_word) begin
            state_r <= ST_FINISH;
          end else begin
            base_r      <= base_next;
            next_addr_r <= next_addr_r + AW'(1);
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_data_r.found     <= res_found_r;
            out_data_r.bit_index <= res_idx_r;
            state_r              <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // A scan never looks at a word that lies wholly at or beyond the size
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (base_r < size_ext))
    else $error("scan word beyond bitmap size");

  // The bitmap is only written by the clearing pass or in idle
  assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ((state_r == ST_CLEAR) || (state_r == ST_IDLE)))
    else $error("bitmap written during a search");

  // A not-found result always carries index zero
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.found) |-> (out_data_r.bit_index == '0))
    else $error("not-found result with nonzero index");

  // The clearing pass covers every word before items are taken
  assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_IDLE) && ($past(state_r) == ST_CLEAR)) |->
      ($past(clr_addr_r) == LAST_ADDR))
    else $error("clearing pass ended early");

  // A result only leaves the finish state into a free output register
  assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_FINISH) && out_valid_r && out_stall) |=> (state_r == ST_FINISH))
    else $error("result dropped while output stalled");

endmodule

// ===== hdl/bfnb_ram.sv =====
// Simple dual-port RAM: one write port, one read port, registered read data.
module bfnb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/bfnb_word_scan.sv =====
// Finds the lowest matching bit of one bitmap word inside the window [lo, hi).
module bfnb_word_scan #(
  parameter int WORD_BITS = 64,
  localparam int CNT_W = $clog2(WORD_BITS + 1),
  localparam int POS_W = $clog2(WORD_BITS)
) (
  input  logic [WORD_BITS-1:0] word,
  input  logic                 want_set,
  input  logic [CNT_W-1:0]     lo,
  input  logic [CNT_W-1:0]     hi,
  output logic                 hit,
  output logic [POS_W-1:0]     pos
);

  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] cand;

  // Window mask: only bits between start and size take part
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      mask[i] = (CNT_W'(i) >= lo) && (CNT_W'(i) < hi);
    end
  end

  // Searching for a zero is searching the inverted word for a one
  assign cand = (want_set ? word : ~word) & mask;
  assign hit  = |cand;

  // Lowest set bit of the candidates
  always_comb begin
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        pos = POS_W'(i);
      end
    end
  end

endmodule
